@@ src/abs_pkg.sv @@
// ----------------------------------------------------------------------------
// abs_pkg: shared types and helpers for the alpha blend sprite blitter
// Command, status and register codes, the queue entry and the /255 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package abs_pkg;

    typedef enum logic [1:0] {
        CMD_BLEND = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_BLEND = 3'd0,
        ST_CLIP  = 3'd1,
        ST_CLEAR = 3'd2,
        ST_READ  = 3'd3,
        ST_BAD   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_FRAME_W     = 3'd0,
        CFG_FRAME_H     = 3'd1,
        CFG_SPRITE_W    = 3'd2,
        CFG_SPRITE_H    = 3'd3,
        CFG_POS_X       = 3'd4,
        CFG_POS_Y       = 3'd5,
        CFG_CLEAR_COLOR = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        [8:0]  frame_w;
        logic        [8:0]  frame_h;
        logic        [8:0]  sprite_w;
        logic        [8:0]  sprite_h;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic        [23:0] clear_color;
    } t_cfg;

    // classified item; the status doubles as the operation for the back end
    typedef struct packed {
        t_status          status;
        logic [7:0]       x;
        logic [7:0]       y;
        logic [2:0][7:0]  rgb;    // [2] red, [1] green, [0] blue
        logic [7:0]       alpha;
    } t_entry;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = 1;

    // floor(v / 255) for v <= 255*255: reciprocal estimate plus one correction
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [24:0] t;
        logic [7:0]  q;
        logic [16:0] qm;
        logic [16:0] r;
        t  = {1'b0, v, 8'd0} + 25'(v);
        q  = t[23:16];
        qm = {1'b0, q, 8'd0} - 17'(q);
        r  = 17'(v) - qm;
        if (r >= 17'd255) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ src/alpha_blend_sprite_blit.sv @@
// ----------------------------------------------------------------------------
// alpha_blend_sprite_blit: source-over sprite blending into an RGB888 frame
// Config registers, front classifier, item queue and frame store back end.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: tuser carries the command (blend, clear,
// read), tdata the sprite pixel and frame address. Every item gives exactly
// one result on the m_ stream: tuser the status, tdata position and color.
// The user must write registers on the cfg channel (always ready) only while
// no item is in flight; the block does not enforce this. The front end
// classifies an item in its accept cycle and queues it; the queue takes two
// items, so intake continues while a result waits. The back end runs one
// item at a time through the single-port frame store: read, multiply,
// divide by 255, write. A blend passes the idle, address, exec, data and mix
// states, a read ends in data, a clear in exec, a clipped or bad item in
// idle; the result register loads in the item's last back-end state.
// When the receiver stalls, the result is held and the queue
// fills, then s_tready drops. Reset restores register defaults and empties
// the queue; the frame store is not cleared, so clear pixels before use.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_sprite_blit #(
    parameter int unsigned MAX_FRAME_WIDTH  = 256,
    parameter int unsigned MAX_FRAME_HEIGHT = 256,
    parameter int unsigned MAX_SPRITE_SIZE  = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // sprite_col, sprite_row, src_red, src_green, src_blue, src_alpha, addr_x, addr_y
    input  wire  [63:0] s_tdata,
    // cmd
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // out_x, out_y, out_red, out_green, out_blue
    output logic [39:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);

    abs_pkg::t_cfg    r_cfg;
    logic             push, full, pop, empty;
    abs_pkg::t_entry  entry, head;
    abs_pkg::t_status status;
    logic [7:0]       out_x, out_y;
    logic [2:0][7:0]  out_rgb;

    function automatic logic [8:0] clamp_size(input logic [8:0] v, input int unsigned mx);
        logic [8:0] r;
        r = v;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if (int'(v) > int'(mx)) begin
            r = 9'(mx);
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_w     <= clamp_size(9'd256, MAX_FRAME_WIDTH);
            r_cfg.frame_h     <= clamp_size(9'd256, MAX_FRAME_HEIGHT);
            r_cfg.sprite_w    <= 9'd1;
            r_cfg.sprite_h    <= 9'd1;
            r_cfg.pos_x       <= '0;
            r_cfg.pos_y       <= '0;
            r_cfg.clear_color <= '0;
        end else if (i_cfg_valid) begin
            case (abs_pkg::t_cfg_idx'(i_cfg_index))
                abs_pkg::CFG_FRAME_W:
                    r_cfg.frame_w <= clamp_size(i_cfg_data[8:0], MAX_FRAME_WIDTH);
                abs_pkg::CFG_FRAME_H:
                    r_cfg.frame_h <= clamp_size(i_cfg_data[8:0], MAX_FRAME_HEIGHT);
                abs_pkg::CFG_SPRITE_W:
                    r_cfg.sprite_w <= clamp_size(i_cfg_data[8:0], MAX_SPRITE_SIZE);
                abs_pkg::CFG_SPRITE_H:
                    r_cfg.sprite_h <= clamp_size(i_cfg_data[8:0], MAX_SPRITE_SIZE);
                abs_pkg::CFG_POS_X:       r_cfg.pos_x <= signed'(i_cfg_data[10:0]);
                abs_pkg::CFG_POS_Y:       r_cfg.pos_y <= signed'(i_cfg_data[10:0]);
                abs_pkg::CFG_CLEAR_COLOR: r_cfg.clear_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    abs_front u_front (
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_user  (s_tuser),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    abs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    abs_back #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_status (status),
        .o_x      (out_x),
        .o_y      (out_y),
        .o_rgb    (out_rgb)
    );

    assign m_tuser = status;
    assign m_tdata = {out_rgb[0], out_rgb[1], out_rgb[2], out_y, out_x};

endmodule

`default_nettype wire

@@ src/abs_fifo.sv @@
// ----------------------------------------------------------------------------
// abs_fifo: short queue between front and back end
// Two entries of classified items, full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module abs_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  abs_pkg::t_entry i_entry,
    output logic            o_full,
    input  wire             i_pop,
    output abs_pkg::t_entry o_head,
    output logic            o_empty
);

    abs_pkg::t_entry r_mem [abs_pkg::QDEPTH];
    logic [abs_pkg::QAW-1:0] r_wr_ptr;
    logic [abs_pkg::QAW-1:0] r_rd_ptr;
    logic [abs_pkg::QAW:0]   r_count;

    assign o_full  = (r_count == (abs_pkg::QAW+1)'(abs_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/abs_front.sv @@
// ----------------------------------------------------------------------------
// abs_front: item intake and classification
// Maps sprite pixels to screen, checks bounds and queues the classified item.
// ----------------------------------------------------------------------------
`default_nettype none

module abs_front (
    input  wire             i_valid,
    output logic            o_ready,
    input  wire [63:0]      i_data,
    input  wire [1:0]       i_user,
    input  abs_pkg::t_cfg   i_cfg,
    input  wire             i_full,
    output logic            o_push,
    output abs_pkg::t_entry o_entry
);

    logic [7:0]         col, row, ax, ay;
    logic signed [12:0] sx, sy;
    logic signed [12:0] fw_s, fh_s;

    assign col = i_data[7:0];
    assign row = i_data[15:8];
    assign ax  = i_data[55:48];
    assign ay  = i_data[63:56];

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign fw_s = signed'({4'd0, i_cfg.frame_w});
    assign fh_s = signed'({4'd0, i_cfg.frame_h});
    // lower-left corner sits half a sprite (rounded down) below the center
    assign sx = 13'(i_cfg.pos_x) - signed'({5'd0, i_cfg.sprite_w[8:1]})
              + signed'({5'd0, col});
    assign sy = 13'(i_cfg.pos_y) - signed'({5'd0, i_cfg.sprite_h[8:1]})
              + signed'({5'd0, row});

    always_comb begin
        o_entry.rgb   = {i_data[23:16], i_data[31:24], i_data[39:32]};
        o_entry.alpha = i_data[47:40];
        o_entry.x     = ax;
        o_entry.y     = ay;
        o_entry.status = abs_pkg::ST_BAD;
        case (abs_pkg::t_cmd'(i_user))
            abs_pkg::CMD_BLEND: begin
                o_entry.x = sx[7:0];
                o_entry.y = sy[7:0];
                if ({1'b0, col} >= i_cfg.sprite_w || {1'b0, row} >= i_cfg.sprite_h) begin
                    o_entry.status = abs_pkg::ST_BAD;
                end else if (sx < 0 || sy < 0 || sx >= fw_s || sy >= fh_s) begin
                    o_entry.status = abs_pkg::ST_CLIP;
                end else begin
                    o_entry.status = abs_pkg::ST_BLEND;
                end
            end
            abs_pkg::CMD_CLEAR, abs_pkg::CMD_READ: begin
                if ({1'b0, ax} >= i_cfg.frame_w || {1'b0, ay} >= i_cfg.frame_h) begin
                    o_entry.status = abs_pkg::ST_BAD;
                end else if (abs_pkg::t_cmd'(i_user) == abs_pkg::CMD_CLEAR) begin
                    o_entry.status = abs_pkg::ST_CLEAR;
                end else begin
                    o_entry.status = abs_pkg::ST_READ;
                end
            end
            default: o_entry.status = abs_pkg::ST_BAD;
        endcase
    end

endmodule

`default_nettype wire

@@ src/abs_back.sv @@
// ----------------------------------------------------------------------------
// abs_back: frame store and execution sequencer
// Address, read, blend and write of one queued item at a time, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abs_back #(
    parameter int unsigned MAX_FRAME_WIDTH  = 256,
    parameter int unsigned MAX_FRAME_HEIGHT = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  abs_pkg::t_cfg    i_cfg,
    input  wire              i_empty,
    input  abs_pkg::t_entry  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output abs_pkg::t_status o_status,
    output logic [7:0]       o_x,
    output logic [7:0]       o_y,
    output logic [2:0][7:0]  o_rgb
);

    localparam int unsigned DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_DATA,
        S_MIX
    } t_state;

    t_state           r_state;
    abs_pkg::t_entry  r_cur;
    logic [AW-1:0]    r_addr;
    logic [23:0]      r_rdata;
    logic [2:0][15:0] r_sum;
    logic             r_out_valid;
    abs_pkg::t_status r_out_status;
    logic [7:0]       r_out_x;
    logic [7:0]       r_out_y;
    logic [2:0][7:0]  r_out_rgb;

    logic [23:0]      r_mem [DEPTH];

    logic             out_free;
    logic             start;
    logic             skip;
    logic             wr_en;
    logic [23:0]      wr_data;
    logic [16:0]      lin_addr;
    logic [2:0][7:0]  mixed;
    logic [2:0][15:0] n_sum;

    assign out_free = !r_out_valid || i_ready;
    assign start    = (r_state == S_IDLE) && !i_empty && out_free;
    assign skip     = (i_head.status == abs_pkg::ST_CLIP)
                   || (i_head.status == abs_pkg::ST_BAD);
    assign o_pop    = start;

    assign lin_addr = 17'(r_cur.y) * 17'(i_cfg.frame_w) + 17'(r_cur.x);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mixed[c] = abs_pkg::div255(r_sum[c]);
            n_sum[c] = 16'(17'(16'(r_cur.alpha) * 16'(r_cur.rgb[c]))
                     + 17'(16'(8'd255 - r_cur.alpha) * 16'(r_rdata[c*8 +: 8])));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = i_cfg.clear_color;
        if (r_state == S_EXEC && r_cur.status == abs_pkg::ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == S_MIX) begin
            wr_en   = 1'b1;
            wr_data = mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a skipped item reloads the result register in the same cycle
            if (r_out_valid && i_ready && !(start && skip)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cur <= i_head;
                        if (skip) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= i_head.status;
                            r_out_x      <= '0;
                            r_out_y      <= '0;
                            r_out_rgb    <= '0;
                        end else begin
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    r_addr  <= AW'(lin_addr);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_cur.status == abs_pkg::ST_CLEAR) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_cur.status;
                        r_out_x      <= r_cur.x;
                        r_out_y      <= r_cur.y;
                        r_out_rgb    <= i_cfg.clear_color;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (r_cur.status == abs_pkg::ST_READ) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_cur.status;
                        r_out_x      <= r_cur.x;
                        r_out_y      <= r_cur.y;
                        r_out_rgb    <= r_rdata;
                        r_state      <= S_IDLE;
                    end else begin
                        r_sum   <= n_sum;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= r_cur.status;
                    r_out_x      <= r_cur.x;
                    r_out_y      <= r_cur.y;
                    r_out_rgb    <= mixed;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_x      = r_out_x;
    assign o_y      = r_out_y;
    assign o_rgb    = r_out_rgb;

    // the result register is free for the whole time an item is in flight
    a_out_idle_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while an item is in flight");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_EXEC) || (r_state == S_MIX)))
        else $error("frame store written outside exec or mix");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_status == abs_pkg::ST_CLIP)
                      || (r_out_status == abs_pkg::ST_BAD)))
        |-> (r_out_x == '0 && r_out_y == '0 && r_out_rgb == '0))
        else $error("clipped or bad result carries data");

    a_mix_follows_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> ($past(r_state) == S_DATA))
        else $error("mix entered without read data");

endmodule

`default_nettype wire
